>>> hdl/rpfb_pkg.sv
package rpfb_pkg;

    localparam int MATRIX_WIDTH  = 16;
    localparam int MATRIX_HEIGHT = 32;

    localparam int XW = (MATRIX_WIDTH > 1) ? $clog2(MATRIX_WIDTH) : 1;
    localparam int YW = (MATRIX_HEIGHT > 1) ? $clog2(MATRIX_HEIGHT) : 1;
    localparam int AW = XW + YW;
    localparam int DEPTH = 1 << AW;
    localparam int CW = (XW > YW) ? XW : YW;

    localparam int PIX_W = 24;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    localparam logic [7:0] WIDTH_B  = 8'(MATRIX_WIDTH);
    localparam logic [7:0] HEIGHT_B = 8'(MATRIX_HEIGHT);
    localparam logic [CW-1:0] LAST_X = CW'(MATRIX_WIDTH - 1);
    localparam logic [CW-1:0] LAST_Y = CW'(MATRIX_HEIGHT - 1);

    typedef enum logic [3:0] {
        ACT_SET      = 4'd0,
        ACT_GET      = 4'd1,
        ACT_COPY     = 4'd2,
        ACT_SHIFT_LX = 4'd3,
        ACT_SHIFT_HX = 4'd4,
        ACT_SHIFT_HY = 4'd5,
        ACT_SHIFT_LY = 4'd6,
        ACT_CLR_ROWS = 4'd7,
        ACT_CLR_ALL  = 4'd8
    } action_t;

endpackage

>>> hdl/rpfb_ram.sv
module rpfb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/rgb_pixel_framebuffer_with_shift.sv
// Pixel store of MATRIX_WIDTH x MATRIX_HEIGHT 24-bit RGB pixels in one
// single-port-write, registered-read RAM, one operation per input transfer and
// exactly one result transfer per operation. After reset the block sweeps the
// RAM to zero, one pixel a cycle, before s_tready first rises. Set writes the
// RAM directly; get and copy do one RAM read, then the write or capture.
// Shifts and clear-rows walk the lines in range one pixel a cycle, and
// clear-all walks the whole RAM the same way; the single RAM write port
// sets this pace. A result waits in the output register while the next
// transfer is taken; a new result stalls only while that register is still full.
module rgb_pixel_framebuffer_with_shift (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action, x_pos, y_pos, src_x, src_y, red, green, blue, range_from, range_to
    input  logic [rpfb_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red_out, green_out, blue_out, lit, status
    output logic [rpfb_pkg::M_TDATA_W-1:0]  m_tdata
);

    import rpfb_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    logic [3:0]       s_action;
    logic [7:0]       s_x, s_y, s_sx, s_sy, s_red, s_green, s_blue, s_from, s_to;

    assign s_action = s_tdata[3:0];
    assign s_x      = s_tdata[11:4];
    assign s_y      = s_tdata[19:12];
    assign s_sx     = s_tdata[27:20];
    assign s_sy     = s_tdata[35:28];
    assign s_red    = s_tdata[43:36];
    assign s_green  = s_tdata[51:44];
    assign s_blue   = s_tdata[59:52];
    assign s_from   = s_tdata[67:60];
    assign s_to     = s_tdata[75:68];

    state_t           state_reg, state_next;
    logic [CW-1:0]    outer_reg, outer_next;
    logic [CW-1:0]    inner_reg, inner_next;
    logic [CW-1:0]    to_reg, to_next;
    logic             row_reg, row_next;
    logic             asc_reg, asc_next;
    logic             clr_reg, clr_next;
    logic             resp_reg, resp_next;
    logic             get_reg, get_next;
    logic             wr_pend_reg, wr_pend_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;
    logic             wr_zero_reg, wr_zero_next;
    logic [PIX_W-1:0] res_pix_reg, res_pix_next;
    logic             res_lit_reg, res_lit_next;
    logic             res_status_reg, res_status_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [PIX_W-1:0] m_pix_reg, m_pix_next;
    logic             m_lit_reg, m_lit_next;
    logic             m_status_reg, m_status_next;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [PIX_W-1:0] mem_wdata, mem_rdata;

    logic             s_xfer, set_wr, xy_in, src_in;
    logic             rows_ok, cols_ok, at_end, out_free;
    logic [CW-1:0]    inner_last, src_inner;
    logic [AW-1:0]    dest_addr, src_addr;

    rpfb_ram #(
        .WIDTH(PIX_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign xy_in    = (s_x < WIDTH_B) && (s_y < HEIGHT_B);
    assign src_in   = (s_sx < WIDTH_B) && (s_sy < HEIGHT_B);
    assign rows_ok  = (s_from <= s_to) && (s_to < HEIGHT_B);
    assign cols_ok  = (s_from <= s_to) && (s_to < WIDTH_B);
    assign set_wr   = s_xfer && (action_t'(s_action) == ACT_SET) && xy_in;
    assign out_free = !m_tvalid_reg || m_tready;

    // walker addressing
    assign inner_last = row_reg ? LAST_X : LAST_Y;
    assign at_end     = asc_reg ? (inner_reg == inner_last) : (inner_reg == '0);
    assign src_inner  = asc_reg ? inner_reg + 1'b1 : inner_reg - 1'b1;
    assign dest_addr  = row_reg ? {outer_reg[YW-1:0], inner_reg[XW-1:0]}
                                : {inner_reg[YW-1:0], outer_reg[XW-1:0]};
    assign src_addr   = row_reg ? {outer_reg[YW-1:0], src_inner[XW-1:0]}
                                : {src_inner[YW-1:0], outer_reg[XW-1:0]};

    assign mem_we    = set_wr || wr_pend_reg;
    assign mem_waddr = set_wr ? {s_y[YW-1:0], s_x[XW-1:0]} : wr_addr_reg;
    assign mem_wdata = set_wr ? {s_red, s_green, s_blue}
                              : (wr_zero_reg ? '0 : mem_rdata);

    always_comb begin
        state_next      = state_reg;
        outer_next      = outer_reg;
        inner_next      = inner_reg;
        to_next         = to_reg;
        row_next        = row_reg;
        asc_next        = asc_reg;
        clr_next        = clr_reg;
        resp_next       = resp_reg;
        get_next        = get_reg;
        wr_pend_next    = 1'b0;
        wr_addr_next    = wr_addr_reg;
        wr_zero_next    = wr_zero_reg;
        res_pix_next    = res_pix_reg;
        res_lit_next    = res_lit_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_pix_next      = m_pix_reg;
        m_lit_next      = m_lit_reg;
        m_status_next   = m_status_reg;
        mem_raddr       = src_addr;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    res_pix_next    = '0;
                    res_lit_next    = 1'b0;
                    res_status_next = 1'b0;
                    state_next      = ST_RESP;
                    get_next        = 1'b0;
                    resp_next       = 1'b1;
                    outer_next      = s_from[CW-1:0];
                    to_next         = s_to[CW-1:0];
                    clr_next        = 1'b0;
                    case (action_t'(s_action))
                        ACT_SET: begin
                            res_status_next = !xy_in;
                        end
                        ACT_GET: begin
                            mem_raddr = {s_y[YW-1:0], s_x[XW-1:0]};
                            if (xy_in) begin
                                get_next   = 1'b1;
                                state_next = ST_READ;
                            end else begin
                                res_status_next = 1'b1;
                            end
                        end
                        ACT_COPY: begin
                            mem_raddr = {s_sy[YW-1:0], s_sx[XW-1:0]};
                            if (xy_in) begin
                                wr_pend_next = 1'b1;
                                wr_addr_next = {s_y[YW-1:0], s_x[XW-1:0]};
                                wr_zero_next = !src_in;
                                state_next   = ST_READ;
                            end else begin
                                res_status_next = 1'b1;
                            end
                        end
                        ACT_SHIFT_LX, ACT_SHIFT_HX, ACT_CLR_ROWS: begin
                            row_next = 1'b1;
                            asc_next = (action_t'(s_action) != ACT_SHIFT_HX);
                            clr_next = (action_t'(s_action) == ACT_CLR_ROWS);
                            inner_next = (action_t'(s_action) == ACT_SHIFT_HX)
                                         ? LAST_X : '0;
                            if (rows_ok) begin
                                state_next = ST_WALK;
                            end else begin
                                res_status_next = 1'b1;
                            end
                        end
                        ACT_SHIFT_HY, ACT_SHIFT_LY: begin
                            row_next = 1'b0;
                            asc_next = (action_t'(s_action) == ACT_SHIFT_LY);
                            inner_next = (action_t'(s_action) == ACT_SHIFT_HY)
                                         ? LAST_Y : '0;
                            if (cols_ok) begin
                                state_next = ST_WALK;
                            end else begin
                                res_status_next = 1'b1;
                            end
                        end
                        ACT_CLR_ALL: begin
                            row_next   = 1'b1;
                            asc_next   = 1'b1;
                            clr_next   = 1'b1;
                            inner_next = '0;
                            outer_next = '0;
                            to_next    = LAST_Y;
                            state_next = ST_WALK;
                        end
                        default: begin
                            res_status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (get_reg) begin
                    res_pix_next = mem_rdata;
                    res_lit_next = |mem_rdata;
                end
                state_next = ST_RESP;
            end
            ST_WALK: begin
                wr_pend_next = 1'b1;
                wr_addr_next = dest_addr;
                wr_zero_next = clr_reg || at_end;
                if (at_end) begin
                    inner_next = asc_reg ? '0 : inner_last;
                    if (outer_reg == to_reg) begin
                        state_next = ST_DRAIN;
                    end else begin
                        outer_next = outer_reg + 1'b1;
                    end
                end else begin
                    inner_next = src_inner;
                end
            end
            ST_DRAIN: begin
                state_next = resp_reg ? ST_RESP : ST_IDLE;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_pix_next    = res_pix_reg;
                    m_lit_next    = res_lit_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // reset starts the clearing sweep as a clear-all without a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_WALK;
            outer_reg    <= '0;
            inner_reg    <= '0;
            to_reg       <= LAST_Y;
            row_reg      <= 1'b1;
            asc_reg      <= 1'b1;
            clr_reg      <= 1'b1;
            resp_reg     <= 1'b0;
            get_reg      <= 1'b0;
            wr_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            outer_reg    <= outer_next;
            inner_reg    <= inner_next;
            to_reg       <= to_next;
            row_reg      <= row_next;
            asc_reg      <= asc_next;
            clr_reg      <= clr_next;
            resp_reg     <= resp_next;
            get_reg      <= get_next;
            wr_pend_reg  <= wr_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg    <= wr_addr_next;
        wr_zero_reg    <= wr_zero_next;
        res_pix_reg    <= res_pix_next;
        res_lit_reg    <= res_lit_next;
        res_status_reg <= res_status_next;
        m_pix_reg      <= m_pix_next;
        m_lit_reg      <= m_lit_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, m_status_reg, m_lit_reg,
                       m_pix_reg[7:0], m_pix_reg[15:8], m_pix_reg[23:16]};

endmodule

>>> hdl/rpfb_checker.sv
module rpfb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [rpfb_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rpfb_pkg::M_TDATA_W-1:0] m_tdata
);

    import rpfb_pkg::*;

    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // lit follows the colour
    a_lit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24] == (|m_tdata[23:0])))
        else $error("lit does not match colour");

    // refused operations carry no colour
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[25] |-> m_tdata[23:0] == '0)
        else $error("refused operation returned colour");

    // padding stays zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:26] == '0)
        else $error("padding bits set");

    // no input accepted in the cycle right after reset
    a_sweep: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready && !m_tvalid)
        else $error("ready during clearing sweep");

endmodule

bind rgb_pixel_framebuffer_with_shift rpfb_checker u_rpfb_checker (.*);
